// ===== hdl/register_datagram_framer_checker_assert.svh =====
// Assertion macros shared by the register datagram framer and checker.
`ifndef REGISTER_DATAGRAM_FRAMER_CHECKER_ASSERT_SVH
`define REGISTER_DATAGRAM_FRAMER_CHECKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RDFC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RDFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/rdfc_pkg.sv =====
// Types, constants and the CRC-8 step of the register datagram framer and checker.
`timescale 1ns / 1ps

package rdfc_pkg;

    localparam logic [7:0] SYNC_CODE   = 8'h05;
    localparam logic [7:0] MASTER_CODE = 8'hFF;
    localparam logic [7:0] CRC_POLY    = 8'h07;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_RX    = 2'd2;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_SYNC    = 3'd1;
    localparam logic [2:0] ST_BAD_MASTER  = 3'd2;
    localparam logic [2:0] ST_BAD_REG     = 3'd3;
    localparam logic [2:0] ST_BAD_CRC     = 3'd4;

    localparam logic KIND_TX    = 1'b0;
    localparam logic KIND_REPLY = 1'b1;

    localparam logic [3:0] WRITE_LEN = 4'd8;
    localparam logic [3:0] READ_LEN  = 4'd4;

    localparam int CMD_QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0]  action;
        logic [6:0]  reg_address;
        logic [31:0] write_value;
        logic [7:0]  rx_byte;
    } t_item;

    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_byte;
        logic        last;
        logic [31:0] read_value;
        logic [2:0]  status;
    } t_result;

    typedef struct packed {
        logic        is_reply;
        logic        is_write;
        logic [7:0]  node;
        logic [6:0]  addr;
        logic [31:0] value;
        logic [2:0]  status;
    } t_cmd;

    function automatic logic [7:0] crc_update(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] c;
        c = crc_in;
        for (int i = 0; i < 8; i++) begin
            if (c[7] ^ data[i]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== hdl/rdfc_front.sv =====
// Front end: takes input items, tracks echo and reply state, and issues commands.
`timescale 1ns / 1ps

module rdfc_front
    import rdfc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_item       i_item,
    input  logic [7:0]  i_node,
    output logic        o_push,
    output t_cmd        o_cmd
);

    logic [3:0]  r_echo_left, n_echo_left;
    logic        r_pending, n_pending;
    logic [2:0]  r_count, n_count;
    logic [6:0]  r_exp_reg, n_exp_reg;
    logic [7:0]  r_crc, n_crc;
    logic [31:0] r_data, n_data;
    logic [2:0]  r_first_err, n_first_err;

    logic [2:0]  err_now;
    logic [2:0]  err_merged;

    always_comb begin
        err_now = ST_OK;
        case (r_count)
            3'd0: if (i_item.rx_byte != SYNC_CODE) err_now = ST_BAD_SYNC;
            3'd1: if (i_item.rx_byte != MASTER_CODE) err_now = ST_BAD_MASTER;
            3'd2: if (i_item.rx_byte != {1'b0, r_exp_reg}) err_now = ST_BAD_REG;
            3'd7: if (i_item.rx_byte != r_crc) err_now = ST_BAD_CRC;
            default: err_now = ST_OK;
        endcase
        err_merged = (r_first_err != ST_OK) ? r_first_err : err_now;
    end

    always_comb begin
        n_echo_left = r_echo_left;
        n_pending   = r_pending;
        n_count     = r_count;
        n_exp_reg   = r_exp_reg;
        n_crc       = r_crc;
        n_data      = r_data;
        n_first_err = r_first_err;
        o_push      = 1'b0;
        o_cmd       = '0;
        if (i_valid) begin
            case (i_item.action)
                ACT_WRITE, ACT_READ: begin
                    o_push          = 1'b1;
                    o_cmd.is_reply  = 1'b0;
                    o_cmd.is_write  = (i_item.action == ACT_WRITE);
                    o_cmd.node      = i_node;
                    o_cmd.addr      = i_item.reg_address;
                    o_cmd.value     = i_item.write_value;
                    o_cmd.status    = ST_OK;
                    n_echo_left = (i_item.action == ACT_WRITE) ? WRITE_LEN : READ_LEN;
                    n_count     = 3'd0;
                    n_crc       = 8'h00;
                    n_data      = 32'd0;
                    n_first_err = ST_OK;
                    n_pending   = (i_item.action == ACT_READ);
                    if (i_item.action == ACT_READ) begin
                        n_exp_reg = i_item.reg_address;
                    end
                end
                ACT_RX: begin
                    if (r_echo_left != 4'd0) begin
                        n_echo_left = r_echo_left - 4'd1;
                    end else if (r_pending) begin
                        if (r_count != 3'd7) begin
                            n_count     = r_count + 3'd1;
                            n_crc       = crc_update(r_crc, i_item.rx_byte);
                            n_first_err = err_merged;
                            if (r_count > 3'd2) begin
                                n_data = {r_data[23:0], i_item.rx_byte};
                            end
                        end else begin
                            o_push         = 1'b1;
                            o_cmd.is_reply = 1'b1;
                            o_cmd.value    = (err_merged == ST_OK) ? r_data : 32'd0;
                            o_cmd.status   = err_merged;
                            n_pending      = 1'b0;
                            n_count        = 3'd0;
                            n_crc          = 8'h00;
                            n_data         = 32'd0;
                            n_first_err    = ST_OK;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_echo_left <= '0;
            r_pending   <= 1'b0;
            r_count     <= '0;
            r_exp_reg   <= '0;
            r_crc       <= '0;
            r_data      <= '0;
            r_first_err <= ST_OK;
        end else begin
            r_echo_left <= n_echo_left;
            r_pending   <= n_pending;
            r_count     <= n_count;
            r_exp_reg   <= n_exp_reg;
            r_crc       <= n_crc;
            r_data      <= n_data;
            r_first_err <= n_first_err;
        end
    end

endmodule

// ===== hdl/rdfc_queue.sv =====
// Command queue between the front end and the byte serializer.
`timescale 1ns / 1ps

module rdfc_queue
    import rdfc_pkg::*;
#(
    parameter int DEPTH = CMD_QUEUE_DEPTH
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    input  logic i_pop,
    output t_cmd o_data,
    output logic o_full,
    output logic o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_cmd             r_mem [DEPTH];
    logic [PTR_W:0]   r_wr_ptr;
    logic [PTR_W:0]   r_rd_ptr;

    assign o_empty = (r_wr_ptr == r_rd_ptr);
    assign o_full  = (r_wr_ptr[PTR_W] != r_rd_ptr[PTR_W])
                  && (r_wr_ptr[PTR_W-1:0] == r_rd_ptr[PTR_W-1:0]);
    assign o_data  = r_mem[r_rd_ptr[PTR_W-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr_ptr[PTR_W-1:0]] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

endmodule

// ===== hdl/rdfc_back.sv =====
// Back end: serializes datagrams with a running CRC and holds the result register.
`timescale 1ns / 1ps

module rdfc_back
    import rdfc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    input  logic    i_q_empty,
    output logic    o_q_pop,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_result
);

    logic        r_busy, n_busy;
    t_cmd        r_cmd, n_cmd;
    logic [2:0]  r_idx, n_idx;
    logic [7:0]  r_crc, n_crc;
    logic        r_out_valid, n_out_valid;
    t_result     r_out, n_out;

    logic        out_free;
    logic        is_final;
    logic        emit;
    logic [7:0]  cur_byte;
    t_result     cur_result;

    always_comb begin
        out_free = !r_out_valid || i_pop;
        is_final = r_cmd.is_reply || (r_cmd.is_write ? (r_idx == 3'd7) : (r_idx == 3'd3));
        emit     = r_busy && out_free;
        o_q_pop  = !i_q_empty && (!r_busy || (emit && is_final));

        case (r_idx)
            3'd0:    cur_byte = SYNC_CODE;
            3'd1:    cur_byte = r_cmd.node;
            3'd2:    cur_byte = {r_cmd.is_write, r_cmd.addr};
            3'd3:    cur_byte = r_cmd.value[31:24];
            3'd4:    cur_byte = r_cmd.value[23:16];
            3'd5:    cur_byte = r_cmd.value[15:8];
            3'd6:    cur_byte = r_cmd.value[7:0];
            default: cur_byte = 8'h00;
        endcase
        if (is_final) begin
            cur_byte = r_crc;
        end

        cur_result = '0;
        if (r_cmd.is_reply) begin
            cur_result.kind       = KIND_REPLY;
            cur_result.read_value = r_cmd.value;
            cur_result.status     = r_cmd.status;
        end else begin
            cur_result.kind    = KIND_TX;
            cur_result.tx_byte = cur_byte;
            cur_result.last    = is_final;
            cur_result.status  = ST_OK;
        end
    end

    always_comb begin
        n_busy      = r_busy;
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        n_crc       = r_crc;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (emit) begin
            n_out_valid = 1'b1;
            n_out       = cur_result;
            n_crc       = crc_update(r_crc, cur_byte);
            n_idx       = r_idx + 3'd1;
            if (is_final) begin
                n_busy = 1'b0;
            end
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end
        if (o_q_pop) begin
            n_cmd  = i_cmd;
            n_busy = 1'b1;
            n_idx  = 3'd0;
            n_crc  = 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_crc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_idx       <= n_idx;
            r_crc       <= n_crc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_out <= n_out;
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

endmodule

// ===== hdl/register_datagram_framer_checker.sv =====
// Top level of the register datagram framer and reply checker.
`timescale 1ns / 1ps
`include "register_datagram_framer_checker_assert.svh"

// Master side of a single-wire UART register link. A write item produces eight
// transmit results and a read item four, one per cycle while the output register is
// free, from a byte serializer that folds each byte into the CRC as it goes out.
// The input side takes an item, such as a received byte, every cycle as long as the
// command queue has room; the echo is dropped and a completed reply yields one check
// result. A send item yields one result per byte, eight at most. A finished result
// waits in the output register while the next one is prepared.

module register_datagram_framer_checker
    import rdfc_pkg::*;
#(
    parameter int CmdDepth = CMD_QUEUE_DEPTH
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    input  t_item      i_item,
    output logic       full,
    output logic       empty,
    input  logic       pop,
    output t_result    o_result,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    logic [7:0] r_node;
    logic       accept;
    logic       cmd_push;
    t_cmd       cmd_in;
    t_cmd       cmd_out;
    logic       q_full;
    logic       q_empty;
    logic       q_pop;

    assign o_cfg_ready = 1'b1;
    assign full        = q_full;
    assign accept      = push && !q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node <= 8'h00;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_node <= i_cfg_data;
        end
    end

    rdfc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_item  (i_item),
        .i_node  (r_node),
        .o_push  (cmd_push),
        .o_cmd   (cmd_in)
    );

    rdfc_queue #(
        .DEPTH (CmdDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .i_pop   (q_pop),
        .o_data  (cmd_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    rdfc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd_out),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

    `RDFC_ASSERT_IMP(a_no_push_full, cmd_push, !q_full, "command pushed into a full queue")
    `RDFC_ASSERT_IMP(a_reply_clean, !empty && o_result.kind == KIND_REPLY, o_result.tx_byte == 8'h00 && !o_result.last, "reply result carries transmit fields")
    `RDFC_ASSERT_IMP(a_error_no_value, !empty && o_result.status != ST_OK, o_result.read_value == 32'd0 && o_result.kind == KIND_REPLY, "failed check carries a value")
    `RDFC_ASSERT_NEXT(a_pop_drains, q_pop && q_full, !q_full, "queue stays full after a pop")

endmodule
